FILE: src/shroll_pkg.sv
// Shared types and codes for the shutter roll controller.
// Depends on nothing; every other file of the block imports it.
package shroll_pkg;

  // Command ids carried in the first byte of a pair
  localparam logic [7:0] ID_UP_LIMIT   = 8'd1;
  localparam logic [7:0] ID_DOWN_LIMIT = 8'd2;
  localparam logic [7:0] ID_ROLL       = 8'd3;

  // Shutter position codes
  localparam logic [1:0] POS_UP        = 2'd0;
  localparam logic [1:0] POS_DOWN      = 2'd1;
  localparam logic [1:0] POS_ROLL_UP   = 2'd2;
  localparam logic [1:0] POS_ROLL_DOWN = 2'd3;

  // Target direction codes
  localparam logic TARGET_UP = 1'b0;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_SET_UP   = 3'd1,
    OP_SET_DOWN = 3'd2,
    OP_ROLL     = 3'd3,
    OP_TICK     = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  value;
    logic [15:0] distance;
  } entry_t;

endpackage

FILE: src/shroll_front.sv
// Front end: pairs command bytes and classifies every transaction.
// Depends on shroll_pkg.
module shroll_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                req_type,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         distance,
  output logic                push_valid,
  output shroll_pkg::entry_t  push_entry,
  input  logic                queue_full
);
  import shroll_pkg::*;

  logic       byte_phase;
  logic [7:0] first_byte;
  logic       accept;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign push_valid = item_valid;

  // Classify the incoming transaction
  always_comb begin
    push_entry.value    = rx_byte;
    push_entry.distance = distance;
    push_entry.op       = OP_HOLD;
    if (req_type) begin
      push_entry.op = OP_TICK;
    end else if (byte_phase) begin
      unique case (first_byte)
        ID_UP_LIMIT:   push_entry.op = OP_SET_UP;
        ID_DOWN_LIMIT: push_entry.op = OP_SET_DOWN;
        ID_ROLL:       push_entry.op = OP_ROLL;
        default:       push_entry.op = OP_HOLD;
      endcase
    end
  end

  // Advance the byte pairing on each accepted command byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= 1'b0;
    end else if (accept && !req_type) begin
      byte_phase <= !byte_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !req_type && !byte_phase) begin
      first_byte <= rx_byte;
    end
  end

endmodule

FILE: src/shroll_queue.sv
// Short first-in first-out queue of classified transactions.
// Depends on shroll_pkg.
module shroll_queue #(
  parameter int DEPTH = shroll_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  shroll_pkg::entry_t  push_entry,
  output logic                full,
  output logic                head_valid,
  output shroll_pkg::entry_t  head_entry,
  input  logic                pop
);
  import shroll_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_ok;
  logic               pop_ok;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign push_ok    = push_valid && !full;
  assign pop_ok     = pop && head_valid;

  // Write the new entry at the tail
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/shroll_back.sv
// Back end: applies commands and ticks to the shutter state and
// registers one result per transaction. Depends on shroll_pkg.
module shroll_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  shroll_pkg::entry_t  head_entry,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          position,
  output logic                red_led,
  output logic                green_led,
  output logic                yellow_led,
  output logic                arrived,
  output logic [15:0]         report_distance
);
  import shroll_pkg::*;

  logic [7:0]  up_limit, up_limit_next;
  logic [7:0]  down_limit, down_limit_next;
  logic        target, target_next;
  logic        armed, armed_next;
  logic [1:0]  cur_pos, cur_pos_next;
  logic        blink, blink_next;
  logic        red, red_next;
  logic        green, green_next;
  logic        yellow, yellow_next;
  logic        arrived_next;
  logic [15:0] report_next;

  assign pop = head_valid && (!result_valid || !result_stall);

  // Work out the next state and the result of the head transaction
  always_comb begin
    up_limit_next   = up_limit;
    down_limit_next = down_limit;
    target_next     = target;
    armed_next      = armed;
    cur_pos_next    = cur_pos;
    blink_next      = blink;
    red_next        = red;
    green_next      = green;
    yellow_next     = yellow;
    arrived_next    = 1'b0;
    report_next     = '0;
    unique case (head_entry.op)
      OP_SET_UP:   up_limit_next = head_entry.value;
      OP_SET_DOWN: down_limit_next = head_entry.value;
      OP_ROLL: begin
        target_next = head_entry.value[0];
        armed_next  = 1'b1;
      end
      OP_TICK: begin
        if (armed && ({1'b0, target} != cur_pos)) begin
          blink_next  = !blink;
          yellow_next = !blink;
          if (target == TARGET_UP) begin
            red_next     = 1'b0;
            cur_pos_next = POS_ROLL_UP;
            if (head_entry.distance <= {8'd0, up_limit}) begin
              cur_pos_next = POS_UP;
              green_next   = 1'b1;
              yellow_next  = 1'b0;
              arrived_next = 1'b1;
              report_next  = head_entry.distance;
              armed_next   = 1'b0;
            end
          end else begin
            green_next   = 1'b0;
            cur_pos_next = POS_ROLL_DOWN;
            if (head_entry.distance >= {8'd0, down_limit}) begin
              cur_pos_next = POS_DOWN;
              red_next     = 1'b1;
              yellow_next  = 1'b0;
              arrived_next = 1'b1;
              report_next  = head_entry.distance;
              armed_next   = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Commit the state on each popped transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      up_limit   <= '0;
      down_limit <= '0;
      target     <= TARGET_UP;
      armed      <= 1'b0;
      cur_pos    <= POS_UP;
      blink      <= 1'b0;
      red        <= 1'b0;
      green      <= 1'b1;
      yellow     <= 1'b0;
    end else if (pop) begin
      up_limit   <= up_limit_next;
      down_limit <= down_limit_next;
      target     <= target_next;
      armed      <= armed_next;
      cur_pos    <= cur_pos_next;
      blink      <= blink_next;
      red        <= red_next;
      green      <= green_next;
      yellow     <= yellow_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      position        <= cur_pos_next;
      red_led         <= red_next;
      green_led       <= green_next;
      yellow_led      <= yellow_next;
      arrived         <= arrived_next;
      report_distance <= report_next;
    end
  end

endmodule

FILE: src/shutter_roll_controller.sv
// Top level of the shutter roll controller: front end, queue and back end.
// Depends on shroll_pkg, shroll_front, shroll_queue and shroll_back.
//
// Accepts one transaction per clock while item_stall is low, either a serial
// command byte or a roll tick carrying a distance, and returns exactly one
// result per transaction, in order, registered first in the queue and then
// in the result register. Byte pairs form commands: id 1 sets the up limit,
// id 2 the down limit, id 3 sets the target from bit 0 and arms rolling;
// other ids are dropped. Throughput is one transaction per cycle while
// result_stall is low, set by the state update in the back end; a stalled
// result backs up into the QUEUE_DEPTH-entry queue before item_stall rises.
// Limits reset to zero, the green lamp resets on.
module shutter_roll_controller #(
  parameter int QUEUE_DEPTH = shroll_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] distance,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  position,
  output logic        red_led,
  output logic        green_led,
  output logic        yellow_led,
  output logic        arrived,
  output logic [15:0] report_distance
);
  import shroll_pkg::*;

  logic   push_valid;
  entry_t push_entry;
  logic   queue_full;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  shroll_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .distance   (distance),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  shroll_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  shroll_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .position        (position),
    .red_led         (red_led),
    .green_led       (green_led),
    .yellow_led      (yellow_led),
    .arrived         (arrived),
    .report_distance (report_distance)
  );

endmodule

FILE: sim/tb_shutter_roll_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench for shutter_roll_controller: command pairs, roll ticks and lamps.
// Depends on shroll_pkg and the shutter_roll_controller RTL; a local predictor supplies
// the expected view of every transaction.
module tb_shutter_roll_controller;
  import shroll_pkg::*;

  // Expected view of the shutter after one transaction
  typedef struct packed {
    logic [1:0]  position;
    logic        red;
    logic        green;
    logic        yellow;
    logic        arrived;
    logic [15:0] report;
  } shutter_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        req_type = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic [15:0] distance = 16'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  position;
  logic        red_led;
  logic        green_led;
  logic        yellow_led;
  logic        arrived;
  logic [15:0] report_distance;

  // Predicted controller state, starting from its reset values
  logic        pair_half = 1'b0;
  logic [7:0]  pending_id = 8'd0;
  logic [7:0]  up_lim = 8'd0;
  logic [7:0]  down_lim = 8'd0;
  logic        roll_target = TARGET_UP;
  logic        armed = 1'b0;
  logic [1:0]  shutter_pos = POS_UP;
  logic        blink = 1'b0;
  logic        red_on = 1'b0;
  logic        green_on = 1'b1;
  logic        yellow_on = 1'b0;

  shutter_view_t pending_views[$];
  int error_count = 0;
  int sent_count = 0;
  int idle_pct = 8;
  int stall_pct = 8;

  shutter_roll_controller dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .req_type        (req_type),
    .rx_byte         (rx_byte),
    .distance        (distance),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .position        (position),
    .red_led         (red_led),
    .green_led       (green_led),
    .yellow_led      (yellow_led),
    .arrived         (arrived),
    .report_distance (report_distance)
  );

  always #1 clk = ~clk;

  // Advance the predicted state by one accepted transaction and queue its view
  task predict_transaction(input logic rq, input logic [7:0] b, input logic [15:0] d);
    shutter_view_t v;
    v.arrived = 1'b0;
    v.report = 16'd0;
    if (!rq) begin
      if (!pair_half) begin
        pending_id = b;
        pair_half = 1'b1;
      end else begin
        pair_half = 1'b0;
        case (pending_id)
          ID_UP_LIMIT: up_lim = b;
          ID_DOWN_LIMIT: down_lim = b;
          ID_ROLL: begin
            roll_target = b[0];
            armed = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (armed && {1'b0, roll_target} != shutter_pos) begin
      blink = ~blink;
      yellow_on = blink;
      if (roll_target == TARGET_UP) begin
        red_on = 1'b0;
        shutter_pos = POS_ROLL_UP;
        if (d <= {8'd0, up_lim}) begin
          shutter_pos = POS_UP;
          green_on = 1'b1;
          yellow_on = 1'b0;
          v.arrived = 1'b1;
          v.report = d;
          armed = 1'b0;
        end
      end else begin
        green_on = 1'b0;
        shutter_pos = POS_ROLL_DOWN;
        if (d >= {8'd0, down_lim}) begin
          shutter_pos = POS_DOWN;
          red_on = 1'b1;
          yellow_on = 1'b0;
          v.arrived = 1'b1;
          v.report = d;
          armed = 1'b0;
        end
      end
    end
    v.position = shutter_pos;
    v.red = red_on;
    v.green = green_on;
    v.yellow = yellow_on;
    pending_views.push_back(v);
  endtask

  // Offer one transaction, with a random gap first, and hold it until accepted
  task send_item(input logic rq, input logic [7:0] b, input logic [15:0] d);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    req_type <= rq;
    rx_byte <= b;
    distance <= d;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_transaction(rq, b, d);
    sent_count++;
  endtask

  task send_pair(input logic [7:0] id, input logic [7:0] val);
    send_item(1'b0, id, 16'($urandom));
    send_item(1'b0, val, 16'($urandom));
  endtask

  task send_tick(input logic [15:0] d);
    send_item(1'b1, 8'($urandom), d);
  endtask

  function logic [7:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Keep most distances near the limits so that rolls finish often
  function logic [15:0] pick_distance();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 300));
  endfunction

  task report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Check each result transaction against the oldest expected view; stall at random
  always @(posedge clk) begin : result_check
    shutter_view_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual position %0h report %0h",
                 $time, position, report_distance);
        error_count++;
      end else begin
        want = pending_views.pop_front();
        report_field("position", want.position, position);
        report_field("red_led", want.red, red_led);
        report_field("green_led", want.green, green_led);
        report_field("yellow_led", want.yellow, yellow_led);
        report_field("arrived", want.arrived, arrived);
        report_field("report_distance", want.report, report_distance);
      end
    end
    result_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Tick straight after reset: disarmed, so the reset lamps show
  task test_reset_view();
    send_tick(16'h0000);
  endtask

  // Unknown ids are consumed; a tick between the bytes of a pair leaves the pairing alone
  task test_unknown_ids();
    send_item(1'b0, 8'h00, 16'hFFFF);
    send_tick(16'hFFFF);
    send_item(1'b0, 8'hFF, 16'h0000);
    send_pair(8'hFF, 8'h00);
  endtask

  // Roll down with the widest limit, repeat the roll command, then arrive
  task test_roll_down();
    send_pair(ID_DOWN_LIMIT, 8'd255);
    send_pair(ID_UP_LIMIT, 8'd200);
    send_pair(ID_ROLL, 8'h01);
    send_tick(16'd254);
    send_pair(ID_ROLL, 8'hFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
  endtask

  // Armed at the current position holds; then roll up and arrive on the limit itself
  task test_roll_at_target();
    send_pair(ID_ROLL, 8'h01);
    send_tick(16'd0);
    send_pair(ID_ROLL, 8'hFE);
    send_tick(16'd201);
    send_tick(16'd200);
  endtask

  // Mostly well-formed roll sequences with random content, some noise
  task test_random_rolls(input int n_items);
    int stop_at;
    int kind;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) send_pair(ID_UP_LIMIT, pick_limit());
        if ($urandom_range(0, 2) == 0) send_pair(ID_DOWN_LIMIT, pick_limit());
        send_pair(ID_ROLL, 8'($urandom));
        repeat ($urandom_range(1, 8)) send_tick(pick_distance());
      end else if (kind == 7) begin
        send_item(1'b0, 8'($urandom), 16'($urandom));
      end else if (kind == 8) begin
        send_pair(8'($urandom_range(0, 5)), 8'($urandom));
      end else begin
        send_tick(16'($urandom));
      end
    end
  endtask

  // Back-to-back transactions with no gaps and no stalls
  task test_steady_stream();
    idle_pct = 0;
    stall_pct = 0;
    test_random_rolls(300);
    idle_pct = 8;
    stall_pct = 8;
  endtask

  initial begin
    #200_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int drain;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_unknown_ids();
    test_roll_down();
    test_roll_at_target();
    test_random_rolls(700);
    test_steady_stream();
    test_random_rolls(500);
    item_valid <= 1'b0;
    // Drain outstanding results, then watch for strays
    drain = 0;
    while (pending_views.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_views.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
